### src/visual_fetch_sequencer_macros.svh
// Assertion macros used by the visual fetch sequencer top level
`ifndef VISUAL_FETCH_SEQUENCER_MACROS_SVH
`define VISUAL_FETCH_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside of reset
`define VFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset
`define VFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vfs_pkg.sv
// Types, codes and constants of the visual fetch sequencer
package vfs_pkg;

    // Field widths
    localparam int POS_BITS = 12;
    localparam int SIZE_W   = 12;
    localparam int FW_W     = 12;
    localparam int TOL_W    = 13;
    localparam int CNT_W    = 8;
    localparam int MISS_W   = 6;
    localparam int DIFF_W   = ((FW_W > POS_BITS + 1) ? FW_W : POS_BITS + 1) + 1;
    localparam int CMP_W    = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

    // Search miss count saturates here
    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    // Operations
    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_ASSIGN = 1'b1;

    // Modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_SEARCH   = 2'd1;
    localparam logic [1:0] MODE_APPROACH = 2'd2;

    // Target kinds
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ITEM = 2'd1;
    localparam logic [1:0] TGT_HOME = 2'd2;

    // Motor commands
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_STOP      = 3'd1;
    localparam logic [2:0] CMD_SEARCH    = 3'd2;
    localparam logic [2:0] CMD_LEFT      = 3'd3;
    localparam logic [2:0] CMD_RIGHT     = 3'd4;
    localparam logic [2:0] CMD_FWD_FAR   = 3'd5;
    localparam logic [2:0] CMD_FWD       = 3'd6;
    localparam logic [2:0] CMD_STOP_RUSH = 3'd7;

    // Events
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_FOUND   = 3'd1;
    localparam logic [2:0] EV_FAILED  = 3'd2;
    localparam logic [2:0] EV_ARRIVED = 3'd3;
    localparam logic [2:0] EV_LOST    = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_CENTER_TOL  = 3'd1;
    localparam logic [2:0] REG_ITEM_CLOSE  = 3'd2;
    localparam logic [2:0] REG_HOME_CLOSE  = 3'd3;
    localparam logic [2:0] REG_FAR_SIZE    = 3'd4;
    localparam logic [2:0] REG_CONFIRM     = 3'd5;
    localparam logic [2:0] REG_LOST        = 3'd6;
    localparam logic [2:0] REG_SEARCH_LIM  = 3'd7;

    localparam int PADDR_W = 5;

    typedef struct packed {
        logic              operation;
        logic              match_found;
        logic [11:0]       pos_x;
        logic [SIZE_W-1:0] size_measure;
        logic [1:0]        new_target;
    } t_in_req;

    typedef struct packed {
        logic [2:0] command;
        logic [1:0] mode_now;
        logic [1:0] target_now;
        logic [2:0] event_res;
    } t_out_req;

    typedef struct packed {
        logic [FW_W-1:0]   frame_width;
        logic [TOL_W-1:0]  center_tolerance;
        logic [SIZE_W-1:0] item_close_size;
        logic [SIZE_W-1:0] home_close_size;
        logic [SIZE_W-1:0] far_size;
        logic [CNT_W-1:0]  confirm_frames;
        logic [CNT_W-1:0]  lost_frames;
        logic [MISS_W-1:0] search_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        target_kind;
        logic [MISS_W-1:0] search_misses;
        logic [CNT_W-1:0]  close_seen;
        logic [CNT_W-1:0]  lost_seen;
    } t_state;

endpackage

### src/vfs_step.sv
// Next-state and result logic for one sequencer request
module vfs_step (
    input  vfs_pkg::t_in_req  i_req,
    input  vfs_pkg::t_cfg     i_cfg,
    input  vfs_pkg::t_state   i_state,
    output vfs_pkg::t_state   o_state,
    output vfs_pkg::t_out_req o_res
);
    import vfs_pkg::*;

    logic [POS_BITS-1:0]      pos;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic                     off_center;
    logic [SIZE_W-1:0]        near_thr;
    logic [MISS_W-1:0]        miss_inc;
    logic [2:0]               cmd;
    logic [2:0]               ev;
    t_state                   nxt;

    // Center error and its magnitude, the near threshold and the saturating miss count
    always_comb begin
        pos        = POS_BITS'(i_req.pos_x);
        diff       = $signed(DIFF_W'(i_cfg.frame_width)) - $signed(DIFF_W'({pos, 1'b0}));
        mag        = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        off_center = CMP_W'(mag) >= CMP_W'(i_cfg.center_tolerance);
        near_thr   = (i_state.target_kind == TGT_HOME) ? i_cfg.home_close_size
                                                       : i_cfg.item_close_size;
        miss_inc   = (i_state.search_misses < MISS_MAX) ? i_state.search_misses + MISS_W'(1)
                                                        : i_state.search_misses;
    end

    // Sequence the modes
    always_comb begin
        nxt = i_state;
        cmd = CMD_NONE;
        ev  = EV_NONE;
        if (i_req.operation == OP_ASSIGN) begin
            if (i_req.new_target <= TGT_HOME) begin
                nxt.target_kind = i_req.new_target;
            end
        end else if (i_state.mode == MODE_IDLE) begin
            if (i_state.target_kind != TGT_NONE) begin
                nxt.mode = MODE_SEARCH;
            end
        end else if (i_state.target_kind == TGT_NONE) begin
            nxt.mode = MODE_IDLE;
        end else if (i_state.mode == MODE_SEARCH) begin
            if (!i_req.match_found) begin
                cmd = CMD_SEARCH;
                nxt.search_misses = miss_inc;
                if (miss_inc > i_cfg.search_limit) begin
                    nxt.search_misses = '0;
                    nxt.target_kind   = TGT_NONE;
                    nxt.mode          = MODE_IDLE;
                    ev                = EV_FAILED;
                end
            end else begin
                nxt.search_misses = '0;
                cmd               = CMD_STOP;
                ev                = EV_FOUND;
                nxt.mode          = MODE_APPROACH;
            end
        end else if (!i_req.match_found) begin
            // approach, target not seen
            if (i_state.lost_seen >= i_cfg.lost_frames) begin
                nxt.lost_seen = '0;
                nxt.mode      = MODE_SEARCH;
                ev            = EV_LOST;
            end else begin
                nxt.lost_seen = i_state.lost_seen + CNT_W'(1);
            end
        end else if (off_center) begin
            cmd = diff[DIFF_W-1] ? CMD_LEFT : CMD_RIGHT;
        end else if (i_req.size_measure > near_thr) begin
            if (i_state.close_seen >= i_cfg.confirm_frames) begin
                nxt.close_seen = '0;
                ev             = EV_ARRIVED;
                if (i_state.target_kind != TGT_HOME) begin
                    cmd             = CMD_STOP_RUSH;
                    nxt.target_kind = TGT_HOME;
                    nxt.mode        = MODE_SEARCH;
                end else begin
                    cmd             = CMD_STOP;
                    nxt.target_kind = TGT_NONE;
                    nxt.mode        = MODE_IDLE;
                end
            end else begin
                nxt.close_seen = i_state.close_seen + CNT_W'(1);
                cmd            = CMD_STOP;
            end
        end else if (i_req.size_measure < i_cfg.far_size) begin
            nxt.close_seen = '0;
            cmd            = CMD_FWD_FAR;
        end else begin
            nxt.close_seen = '0;
            cmd            = CMD_FWD;
        end
    end

    assign o_state          = nxt;
    assign o_res.command    = cmd;
    assign o_res.mode_now   = nxt.mode;
    assign o_res.target_now = nxt.target_kind;
    assign o_res.event_res  = ev;

endmodule

### src/visual_fetch_sequencer.sv
// Top level of the visual fetch sequencer: registers, pipeline and checks
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+----------------
//   frame in  | in        | i_in_valid / o_in_ready    | i_in  (t_in_req)
//   result    | out       | o_out_valid / i_out_ready  | o_out (t_out_req)
//   config    | in        | APB psel/penable/pwrite    | paddr, pwdata
//
// One request a cycle sustained while results are taken; each request passes the input
// register, then the result register. The step logic between the two registers sets
// the clock; state updates as a request moves into the result register.
// Reset (synchronous, active low) clears state, valids and config to defaults.
// A stalled result holds; the input register keeps accepting until both stages fill.
module visual_fetch_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  vfs_pkg::t_in_req             i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output vfs_pkg::t_out_req            o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import vfs_pkg::*;

    `include "visual_fetch_sequencer_macros.svh"

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    t_in_req  r_in;
    logic     r_in_vld;
    t_out_req r_out;
    t_out_req n_out;
    logic     r_out_vld;
    logic     out_free;
    logic     move;
    logic     cfg_wr;
    logic [2:0] reg_idx;

    // Handshake control
    assign out_free    = !r_out_vld || i_out_ready;
    assign move        = r_in_vld && out_free;
    assign o_in_ready  = !r_in_vld || move;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // Capture the input request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    vfs_step u_step (
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Advance state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '{mode: MODE_IDLE, target_kind: TGT_NONE, default: '0};
            r_out_vld <= 1'b0;
        end else begin
            if (move) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= n_out;
        end
    end

    // Configuration writes
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width      <= FW_W'(640);
            r_cfg.center_tolerance <= TOL_W'(60);
            r_cfg.item_close_size  <= SIZE_W'(100);
            r_cfg.home_close_size  <= SIZE_W'(150);
            r_cfg.far_size         <= SIZE_W'(40);
            r_cfg.confirm_frames   <= CNT_W'(3);
            r_cfg.lost_frames      <= CNT_W'(5);
            r_cfg.search_limit     <= MISS_W'(50);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH: r_cfg.frame_width      <= pwdata[FW_W-1:0];
                REG_CENTER_TOL:  r_cfg.center_tolerance <= pwdata[TOL_W-1:0];
                REG_ITEM_CLOSE:  r_cfg.item_close_size  <= pwdata[SIZE_W-1:0];
                REG_HOME_CLOSE:  r_cfg.home_close_size  <= pwdata[SIZE_W-1:0];
                REG_FAR_SIZE:    r_cfg.far_size         <= pwdata[SIZE_W-1:0];
                REG_CONFIRM:     r_cfg.confirm_frames   <= pwdata[CNT_W-1:0];
                REG_LOST:        r_cfg.lost_frames      <= pwdata[CNT_W-1:0];
                REG_SEARCH_LIM:  r_cfg.search_limit     <= pwdata[MISS_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH: prdata = 32'(r_cfg.frame_width);
            REG_CENTER_TOL:  prdata = 32'(r_cfg.center_tolerance);
            REG_ITEM_CLOSE:  prdata = 32'(r_cfg.item_close_size);
            REG_HOME_CLOSE:  prdata = 32'(r_cfg.home_close_size);
            REG_FAR_SIZE:    prdata = 32'(r_cfg.far_size);
            REG_CONFIRM:     prdata = 32'(r_cfg.confirm_frames);
            REG_LOST:        prdata = 32'(r_cfg.lost_frames);
            REG_SEARCH_LIM:  prdata = 32'(r_cfg.search_limit);
            default:         prdata = '0;
        endcase
    end

    // Checks
    `VFS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !o_in_ready, r_in_vld && r_out_vld && !i_out_ready, "input stalled while pipeline not full")
    `VFS_ASSERT_NOW(a_found, i_clk, i_rst_n, o_out_valid && o_out.event_res == EV_FOUND, o_out.command == CMD_STOP && o_out.mode_now == MODE_APPROACH, "found event without stop and approach")
    `VFS_ASSERT_NOW(a_failed, i_clk, i_rst_n, o_out_valid && o_out.event_res == EV_FAILED, o_out.target_now == TGT_NONE && o_out.mode_now == MODE_IDLE, "search failure left a target or mode")
    `VFS_ASSERT_NOW(a_arrived, i_clk, i_rst_n, o_out_valid && o_out.event_res == EV_ARRIVED, (o_out.command == CMD_STOP_RUSH && o_out.target_now == TGT_HOME && o_out.mode_now == MODE_SEARCH) || (o_out.command == CMD_STOP && o_out.target_now == TGT_NONE && o_out.mode_now == MODE_IDLE), "arrival with wrong retarget")
    `VFS_ASSERT_NEXT(a_move_state, i_clk, i_rst_n, !move, $stable(r_state), "state changed without a request")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the visual fetch sequencer
`timescale 1ns / 100ps

module tb_top;
    import vfs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_PAUSE = 4;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_req             i_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_req            o_out;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Requests waiting for the driver, and commands the robot should issue
    t_in_req  pending_requests[$];
    t_out_req pending_commands[$];

    // Shadow configuration and robot state
    t_cfg              cfg;
    logic [1:0]        robot_mode = MODE_IDLE;
    logic [1:0]        robot_target = TGT_NONE;
    logic [MISS_W-1:0] misses = '0;
    logic [CNT_W-1:0]  close_cnt = '0;
    logic [CNT_W-1:0]  lost_cnt = '0;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;

    visual_fetch_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // Advance the shadow robot by one request and return the command it gives
    function automatic t_out_req predict_motor_step(t_in_req rq);
        t_out_req          res;
        int                diff;
        int                mag;
        logic [SIZE_W-1:0] near_thr;
        res = '0;
        res.command = CMD_NONE;
        res.event_res = EV_NONE;
        diff = int'(cfg.frame_width) - 2 * int'(rq.pos_x[POS_BITS-1:0]);
        mag = (diff < 0) ? -diff : diff;
        if (rq.operation == OP_ASSIGN) begin
            // codes above home are dropped
            if (rq.new_target <= TGT_HOME) robot_target = rq.new_target;
        end else if (robot_mode == MODE_IDLE) begin
            if (robot_target != TGT_NONE) robot_mode = MODE_SEARCH;
        end else if (robot_target == TGT_NONE) begin
            robot_mode = MODE_IDLE;
        end else if (robot_mode == MODE_SEARCH) begin
            if (!rq.match_found) begin
                res.command = CMD_SEARCH;
                if (misses != MISS_MAX) misses++;
                if (misses > cfg.search_limit) begin
                    misses = '0;
                    robot_target = TGT_NONE;
                    robot_mode = MODE_IDLE;
                    res.event_res = EV_FAILED;
                end
            end else begin
                misses = '0;
                res.command = CMD_STOP;
                res.event_res = EV_FOUND;
                robot_mode = MODE_APPROACH;
            end
        end else if (!rq.match_found) begin
            // tolerate lost_frames misses, then fall back to search
            if (lost_cnt >= cfg.lost_frames) begin
                lost_cnt = '0;
                robot_mode = MODE_SEARCH;
                res.event_res = EV_LOST;
            end else begin
                lost_cnt++;
            end
        end else if (mag >= int'(cfg.center_tolerance)) begin
            res.command = (diff < 0) ? CMD_LEFT : CMD_RIGHT;
        end else begin
            near_thr = (robot_target == TGT_HOME) ? cfg.home_close_size : cfg.item_close_size;
            if (rq.size_measure > near_thr) begin
                if (close_cnt >= cfg.confirm_frames) begin
                    close_cnt = '0;
                    res.event_res = EV_ARRIVED;
                    if (robot_target != TGT_HOME) begin
                        res.command = CMD_STOP_RUSH;
                        robot_target = TGT_HOME;
                        robot_mode = MODE_SEARCH;
                    end else begin
                        res.command = CMD_STOP;
                        robot_target = TGT_NONE;
                        robot_mode = MODE_IDLE;
                    end
                end else begin
                    close_cnt++;
                    res.command = CMD_STOP;
                end
            end else if (rq.size_measure < cfg.far_size) begin
                close_cnt = '0;
                res.command = CMD_FWD_FAR;
            end else begin
                close_cnt = '0;
                res.command = CMD_FWD;
            end
        end
        res.mode_now = robot_mode;
        res.target_now = robot_target;
        return res;
    endfunction

    // Drive frame requests, predicting each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_commands.push_back(predict_motor_step(pending_requests[0]));
                void'(pending_requests.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in <= pending_requests[0];
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = pick_idle_len();
                        if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(30, 100);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Take results with random back-pressure and check them
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_commands.size() == 0) begin
                    note_mismatch($sformatf("unexpected result %p", o_out));
                end else begin
                    want = pending_commands.pop_front();
                    if (o_out.command !== want.command)
                        note_mismatch($sformatf("command got %0d want %0d",
                                                o_out.command, want.command));
                    if (o_out.mode_now !== want.mode_now)
                        note_mismatch($sformatf("mode_now got %0d want %0d",
                                                o_out.mode_now, want.mode_now));
                    if (o_out.target_now !== want.target_now)
                        note_mismatch($sformatf("target_now got %0d want %0d",
                                                o_out.target_now, want.target_now));
                    if (o_out.event_res !== want.event_res)
                        note_mismatch($sformatf("event_res got %0d want %0d",
                                                o_out.event_res, want.event_res));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if (recv_calm > 0) begin
                recv_calm--;
                i_out_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                recv_stall = pick_idle_len();
                i_out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 99) < 3) recv_calm = $urandom_range(30, 100);
                i_out_ready <= 1'b1;
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // One APB write: setup, access, release
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: cfg.frame_width = val[FW_W-1:0];
            REG_CENTER_TOL:  cfg.center_tolerance = val[TOL_W-1:0];
            REG_ITEM_CLOSE:  cfg.item_close_size = val[SIZE_W-1:0];
            REG_HOME_CLOSE:  cfg.home_close_size = val[SIZE_W-1:0];
            REG_FAR_SIZE:    cfg.far_size = val[SIZE_W-1:0];
            REG_CONFIRM:     cfg.confirm_frames = val[CNT_W-1:0];
            REG_LOST:        cfg.lost_frames = val[CNT_W-1:0];
            default:         cfg.search_limit = val[MISS_W-1:0];
        endcase
    endtask

    task automatic write_all(input int fw, input int tol, input int ic, input int hc,
                             input int far, input int conf, input int lost, input int lim);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_CENTER_TOL, tol);
        write_reg(REG_ITEM_CLOSE, ic);
        write_reg(REG_HOME_CLOSE, hc);
        write_reg(REG_FAR_SIZE, far);
        write_reg(REG_CONFIRM, conf);
        write_reg(REG_LOST, lost);
        write_reg(REG_SEARCH_LIM, lim);
        @(negedge i_clk);
    endtask

    // Wait until every command is back, then let the pipeline settle
    task automatic drain();
        while (pending_requests.size() != 0 || pending_commands.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    function automatic t_in_req make_req(logic op, logic hit, int pos, int sz, logic [1:0] tgt);
        t_in_req rq;
        rq.operation = op;
        rq.match_found = hit;
        rq.pos_x = pos[11:0];
        rq.size_measure = sz[SIZE_W-1:0];
        rq.new_target = tgt;
        return rq;
    endfunction

    function automatic t_in_req assign_req(logic [1:0] tgt);
        return make_req(OP_ASSIGN, 1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), tgt);
    endfunction

    // Camera frame biased toward centered and close targets
    function automatic t_in_req random_frame(logic hit);
        int p;
        int q;
        int thr;
        int sz;
        int r;
        q = int'(cfg.center_tolerance) / 4;
        if ($urandom_range(0, 99) < 60) begin
            p = int'(cfg.frame_width) / 2 + int'($urandom_range(0, 2 * q)) - q;
            if (p < 0) p = 0;
            if (p > 4095) p = 4095;
        end else begin
            p = $urandom_range(0, 4095);
        end
        thr = (cfg.item_close_size > cfg.home_close_size) ? int'(cfg.item_close_size)
                                                          : int'(cfg.home_close_size);
        r = $urandom_range(0, 99);
        if (r < 45) begin
            sz = thr + 1 + int'($urandom_range(0, 60));
            if (sz > 4095) sz = 4095;
        end else if (r < 65 && cfg.far_size != 0) begin
            sz = $urandom_range(0, int'(cfg.far_size) - 1);
        end else begin
            sz = $urandom_range(0, 4095);
        end
        return make_req(OP_FRAME, hit, p, sz, 2'($urandom_range(0, 3)));
    endfunction

    // Episodes: pick a target, then a run of frames with some noise
    task automatic queue_random(input int n);
        int done;
        int len;
        int r;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) pending_requests.push_back(assign_req(TGT_ITEM));
            else if (r < 92) pending_requests.push_back(assign_req(TGT_HOME));
            else pending_requests.push_back(assign_req(2'($urandom_range(0, 3))));
            len = $urandom_range(6, 30);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 4)
                    pending_requests.push_back(assign_req(2'($urandom_range(0, 3))));
                else
                    pending_requests.push_back(random_frame($urandom_range(0, 99) < 80));
            end
            done += len + 1;
        end
    endtask

    task automatic queue_frame(input logic hit, input int pos, input int sz);
        pending_requests.push_back(make_req(OP_FRAME, hit, pos, sz, TGT_NONE));
    endtask

    task automatic queue_assign(input logic [1:0] tgt);
        pending_requests.push_back(make_req(OP_ASSIGN, 1'b0, 0, 0, tgt));
    endtask

    initial begin
        cfg.frame_width = 640;
        cfg.center_tolerance = 60;
        cfg.item_close_size = 100;
        cfg.home_close_size = 150;
        cfg.far_size = 40;
        cfg.confirm_frames = 3;
        cfg.lost_frames = 5;
        cfg.search_limit = 50;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk at reset settings
        queue_frame(1'b0, 0, 0);                // idle with no target
        queue_assign(2'd3);                     // unknown target code
        queue_assign(TGT_HOME);
        queue_assign(TGT_NONE);
        queue_assign(TGT_ITEM);
        queue_frame(1'b0, 0, 0);                // idle to search
        pending_requests.push_back(make_req(OP_FRAME, 1'b0, 4095, 4095, 2'd3));
        queue_frame(1'b1, 320, 0);              // found
        queue_frame(1'b1, 0, 4095);             // steer right
        queue_frame(1'b1, 4095, 4095);          // steer left
        queue_frame(1'b1, 320, 0);              // far forward
        queue_frame(1'b1, 320, 40);             // forward at far edge
        queue_frame(1'b1, 320, 100);            // forward at close edge
        queue_frame(1'b1, 320, 101);            // close, not confirmed
        queue_frame(1'b1, 320, 4095);
        queue_frame(1'b1, 320, 200);
        queue_frame(1'b1, 320, 101);            // item arrival, retarget home
        queue_frame(1'b1, 320, 0);              // found home
        queue_frame(1'b0, 320, 0);              // approach miss
        repeat (4) queue_frame(1'b1, 320, 151); // home arrival on the fourth
        queue_assign(TGT_ITEM);
        queue_frame(1'b0, 0, 0);
        queue_frame(1'b1, 320, 0);
        queue_assign(TGT_NONE);
        queue_frame(1'b1, 320, 0);              // approach without a target
        drain();

        // Saturate the miss count with an unreachable limit, then lower it
        write_reg(REG_SEARCH_LIM, 63);
        @(negedge i_clk);
        queue_assign(TGT_ITEM);
        queue_frame(1'b0, 0, 0);
        repeat (70) pending_requests.push_back(random_frame(1'b0));
        drain();
        write_reg(REG_SEARCH_LIM, 62);
        @(negedge i_clk);
        repeat (3) pending_requests.push_back(random_frame(1'b0));
        drain();

        // Extremes
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        queue_random(80);
        drain();
        write_all(4095, 8191, 4095, 4095, 4095, 255, 255, 63);
        queue_random(80);
        drain();

        // Random moderate settings
        repeat (4) begin
            write_all($urandom_range(0, 4095),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(0, 400),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4),
                      $urandom_range(0, 6),
                      ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(0, 10));
            queue_random(100);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
